// ----- hdl/agf_pkg.sv -----
package agf_pkg;

	// Operand width and derived sizes
	localparam int VALUE_WIDTH = 31;
	localparam int K_W         = $clog2(VALUE_WIDTH);
	localparam int TDATA_W     = ((VALUE_WIDTH + 7) / 8) * 8;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;    // take a new word into the operand registers
		logic step;    // run one binary GCD step
		logic finish;  // write the pair result back to the accumulator
		logic emit;    // with finish: send the result out and clear the accumulator
	} agf_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic done;      // one operand is zero, result is ready
		logic out_free;  // output register can take a result this cycle
	} agf_sts_t;

endpackage

// ----- hdl/array_gcd_fold_unit.sv -----
// Running greatest common divisor over sets of unsigned values.
// Input channel s_*: one value per word, s_tlast marks the final value of
// a set. Output channel m_*: one word per set, the divisor of all values in
// it (0 when every value is zero, the value itself for a one-value set).
// Each accepted word is folded into an accumulator by binary GCD: a load,
// then one step per cycle (halve an even operand, or subtract and halve
// when both are odd), then a write-back. The steps are bounded by the total
// operand bits. s_tready is high only while no word is in flight. The
// result of a set appears on m_* in the cycle after its last word is
// written back.
// When the receiver stalls, the result waits in the output register and the
// next set is still accepted and folded; only the write-back of a further
// result waits until the register is free.
// Reset clears the accumulator, the open set and the output register.
module array_gcd_fold_unit
	import agf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,   // value, pad ignored
	input  logic               s_tlast,   // last_item
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata    // divisor, zero pad
);

	agf_cmd_t               cmd;
	agf_sts_t               sts;
	logic [VALUE_WIDTH-1:0] divisor;

	agf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_last  (s_tlast),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	agf_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_value  (s_tdata[VALUE_WIDTH-1:0]),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_value (divisor),
		.sts       (sts)
	);

	// Pad the divisor to whole bytes
	assign m_tdata = TDATA_W'(divisor);

endmodule

// ----- hdl/agf_ctrl.sv -----
module agf_ctrl
	import agf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_last,
	output logic     in_ready,
	input  agf_sts_t sts,
	output agf_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       last_q;

	// Take a word only when no pair is in flight
	assign in_ready = (state_q == ST_IDLE);

	// Decode commands and next state
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_RUN;
				end
			end
			ST_RUN: begin
				if (!sts.done) begin
					cmd.step = 1'b1;
				end else if (!last_q) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end else if (sts.out_free) begin
					cmd.finish = 1'b1;
					cmd.emit   = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold state and the last flag of the word being folded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) last_q <= in_last;
		end
	end

	a_ctrl_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.step && cmd.finish))
		else $error("step and finish issued together");

	a_ctrl_emit_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> last_q)
		else $error("result emitted for a word without last");

	a_ctrl_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (state_q == ST_IDLE))
		else $error("controller not idle after finish");

endmodule

// ----- hdl/agf_datapath.sv -----
module agf_datapath
	import agf_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  agf_cmd_t               cmd,
	input  logic [VALUE_WIDTH-1:0] in_value,
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic [VALUE_WIDTH-1:0] out_value,
	output agf_sts_t               sts
);

	logic [VALUE_WIDTH-1:0] acc_q;
	logic [VALUE_WIDTH-1:0] a_q;
	logic [VALUE_WIDTH-1:0] b_q;
	logic [K_W-1:0]         k_q;
	logic [VALUE_WIDTH-1:0] out_value_q;
	logic                   out_valid_q;

	logic [VALUE_WIDTH:0]   diff_ab;
	logic [VALUE_WIDTH-1:0] diff_ba;
	logic                   a_ge_b;
	logic [VALUE_WIDTH-1:0] result;

	// Compare and subtract for the odd-odd step
	assign diff_ab = {1'b0, a_q} - {1'b0, b_q};
	assign diff_ba = b_q - a_q;
	assign a_ge_b  = ~diff_ab[VALUE_WIDTH];

	// Restore the common power of two
	assign result = VALUE_WIDTH'((a_q | b_q) << k_q);

	assign sts.done     = (a_q == '0) || (b_q == '0);
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;

	// Operand registers: load a pair, then advance one binary GCD step per cycle
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q <= acc_q;
			b_q <= in_value;
			k_q <= '0;
		end else if (cmd.step) begin
			priority if (!a_q[0] && !b_q[0]) begin
				a_q <= a_q >> 1;
				b_q <= b_q >> 1;
				k_q <= k_q + K_W'(1);
			end else if (!a_q[0]) begin
				a_q <= a_q >> 1;
			end else if (!b_q[0]) begin
				b_q <= b_q >> 1;
			end else if (a_ge_b) begin
				a_q <= diff_ab[VALUE_WIDTH-1:0] >> 1;
			end else begin
				b_q <= diff_ba >> 1;
			end
		end
	end

	// Accumulator: take the pair result, clear after a set closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.finish) begin
			acc_q <= cmd.emit ? '0 : result;
		end
	end

	// Output register: hold the word until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) out_value_q <= result;
	end

	a_dp_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("result would overwrite an unsent word");

	a_dp_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> !sts.done)
		else $error("step issued with a zero operand");

	a_dp_acc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (acc_q == '0))
		else $error("accumulator not cleared after a set");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
	import agf_pkg::*;

	localparam int PAD_W        = TDATA_W - VALUE_WIDTH;
	localparam int WORD_TARGET  = 900;
	localparam int LONG_HOLD    = 600;
	localparam int HOLD_AT_WORD = 300;
	localparam int DRAIN_CYCLES = 2 * VALUE_WIDTH + 16;
	localparam int PLAN_ROWS    = 24;
	localparam longint unsigned VALUE_MAX = (64'd1 << VALUE_WIDTH) - 1;

	typedef logic [VALUE_WIDTH-1:0] value_t;

	// one directed word; want is used only where typed is set
	typedef struct packed {
		value_t value;
		logic   last;
		logic   pad;
		logic   typed;
		value_t want;
	} plan_row_t;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata;   // value, pad
	logic               s_tlast;   // last_item
	logic               m_tvalid;
	logic               m_tready;
	logic [TDATA_W-1:0] m_tdata;   // divisor, pad

	// predictor state and the divisors still owed by the block
	value_t divisor_q[$];
	value_t acc_divisor   = '0;
	logic   set_open      = 1'b0;
	value_t oldest_divisor;
	int     mismatches    = 0;
	int     words_sent    = 0;
	logic   calm          = 1'b0;
	logic   long_hold_req = 1'b0;

	plan_row_t plan [PLAN_ROWS] = '{
		'{31'h0,        1'b1, 1'b0, 1'b1, 31'h0},
		'{31'h7FFFFFFF, 1'b1, 1'b0, 1'b1, 31'h7FFFFFFF},
		'{31'h1,        1'b1, 1'b0, 1'b1, 31'h1},
		'{31'h0,        1'b0, 1'b0, 1'b0, 31'h0},
		'{31'h0,        1'b0, 1'b0, 1'b0, 31'h0},
		'{31'h0,        1'b1, 1'b0, 1'b1, 31'h0},
		'{31'h0,        1'b0, 1'b0, 1'b0, 31'h0},
		'{31'd12,       1'b0, 1'b0, 1'b0, 31'h0},
		'{31'h0,        1'b1, 1'b0, 1'b1, 31'd12},
		'{31'h7FFFFFFF, 1'b0, 1'b0, 1'b0, 31'h0},
		'{31'h7FFFFFFF, 1'b1, 1'b0, 1'b1, 31'h7FFFFFFF},
		'{31'h7FFFFFFF, 1'b0, 1'b0, 1'b0, 31'h0},
		'{31'h1,        1'b1, 1'b0, 1'b1, 31'h1},
		'{31'h40000000, 1'b0, 1'b0, 1'b0, 31'h0},
		'{31'h20000000, 1'b0, 1'b0, 1'b0, 31'h0},
		'{31'h60000000, 1'b1, 1'b0, 1'b1, 31'h20000000},
		'{31'd36,       1'b0, 1'b1, 1'b0, 31'h0},
		'{31'd24,       1'b1, 1'b1, 1'b1, 31'd12},
		'{31'd48,       1'b0, 1'b0, 1'b0, 31'h0},
		'{31'd18,       1'b0, 1'b0, 1'b0, 31'h0},
		'{31'd30,       1'b0, 1'b0, 1'b0, 31'h0},
		'{31'd84,       1'b1, 1'b0, 1'b0, 31'h0},
		'{31'h2AAAAAAA, 1'b0, 1'b0, 1'b0, 31'h0},
		'{31'h55555555, 1'b1, 1'b0, 1'b0, 31'h0}
	};

	array_gcd_fold_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// give up on a hung run
	initial begin
		#4_000_000;
		$display("array_gcd_fold_unit regression: fail");
		$finish;
	end

	// Euclid on a pair, gcd(x, 0) = x
	function automatic value_t euclid(input value_t a, input value_t b);
		value_t r;
		while (b != 0) begin
			r = a % b;
			a = b;
			b = r;
		end
		return a;
	endfunction

	// offer one word after a random gap, then fold it in once taken
	task automatic send_word(input value_t v, input logic last, input logic pad,
		input logic typed, input value_t want);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 13);
		@(negedge clk);
		for (int i = 0; i < gap; i++) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{PAD_W{pad}}, v};
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);

		// first value of a set opens it, later ones fold in
		acc_divisor = set_open ? euclid(acc_divisor, v) : v;
		set_open    = 1'b1;
		if (last) begin
			divisor_q.push_back(typed ? want : acc_divisor);
			acc_divisor = '0;
			set_open    = 1'b0;
		end
		words_sent++;
		if (words_sent == HOLD_AT_WORD)
			long_hold_req = 1'b1;
	endtask

	// stimulus: directed plan, then random sets
	initial begin : sender
		int             set_len;
		int             flavour;
		int             bits;
		value_t         factor;
		value_t         v;
		longint unsigned span;
		longint unsigned mult;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tlast  = 1'b0;
		@(posedge arst_n);

		for (int r = 0; r < PLAN_ROWS; r++)
			send_word(plan[r].value, plan[r].last, plan[r].pad, plan[r].typed, plan[r].want);

		while (words_sent < WORD_TARGET) begin
			if ($urandom_range(0, 15) == 0)
				calm = !calm;
			set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 14) : $urandom_range(1, 5);
			flavour = $urandom_range(0, 19);
			bits    = $urandom_range(1, VALUE_WIDTH);
			factor  = value_t'($urandom) & ((value_t'(1) << bits) - 1);
			if (factor == 0)
				factor = 1;
			span = VALUE_MAX / factor;
			for (int k = 0; k < set_len; k++) begin
				if (flavour < 12) begin
					// multiples of a shared factor, some zeros among them
					mult = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, int'(span));
					v    = value_t'(factor * mult);
				end else if (flavour < 17) begin
					v = value_t'($urandom);
				end else begin
					case ($urandom_range(0, 3))
						0: v = '0;
						1: v = '1;
						2: v = value_t'(1) << $urandom_range(0, VALUE_WIDTH - 1);
						default: v = value_t'($urandom);
					endcase
				end
				send_word(v, k == set_len - 1, $urandom_range(0, 31) == 0, 1'b0, '0);
			end
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (divisor_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("array_gcd_fold_unit regression: pass");
		else
			$display("array_gcd_fold_unit regression: fail");
		$finish;
	end

	// receiver: random stall after each word, one long hold-off
	initial begin : receiver
		int   hold;
		logic took;
		hold     = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			took = m_tvalid && m_tready;
			@(negedge clk);
			if (long_hold_req) begin
				hold          = LONG_HOLD;
				long_hold_req = 1'b0;
			end else if (took) begin
				hold = calm ? 0 : $urandom_range(0, 13);
			end
			if (hold > 0) begin
				m_tready <= 1'b0;
				hold--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// compare each output word with the oldest owed divisor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (divisor_q.size() == 0) begin
				$error("divisor: expected none, actual %0d", m_tdata[VALUE_WIDTH-1:0]);
				mismatches++;
			end else begin
				oldest_divisor = divisor_q.pop_front();
				if (m_tdata[VALUE_WIDTH-1:0] !== oldest_divisor) begin
					$error("divisor: expected %0d, actual %0d",
						oldest_divisor, m_tdata[VALUE_WIDTH-1:0]);
					mismatches++;
				end
			end
		end
	end

endmodule
